// ===== sv/slx_pkg.sv =====
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types, codes and character tables for the source lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package slx_pkg;

  localparam logic [16:0] MAX_SOURCE = 17'd65535;

  localparam logic [1:0] REC_TOKEN = 2'd0;
  localparam logic [1:0] REC_BYTE  = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  localparam logic [2:0] ERR_COMMENT = 3'd0;
  localparam logic [2:0] ERR_NUMBER  = 3'd1;
  localparam logic [2:0] ERR_HEX     = 3'd2;
  localparam logic [2:0] ERR_ESCAPE  = 3'd3;
  localparam logic [2:0] ERR_STRING  = 3'd4;
  localparam logic [2:0] ERR_CHAR    = 3'd5;
  localparam logic [2:0] ERR_LONG    = 3'd6;

  localparam logic [5:0] TK_ADD = 6'd0, TK_ADDASSIGN = 6'd1, TK_SUB = 6'd2,
    TK_SUBASSIGN = 6'd3, TK_ARROW = 6'd4, TK_MUL = 6'd5, TK_MULASSIGN = 6'd6,
    TK_DIV = 6'd7, TK_DIVASSIGN = 6'd8, TK_BAND = 6'd9, TK_AND = 6'd10,
    TK_BOR = 6'd11, TK_OR = 6'd12, TK_ASSIGN = 6'd13, TK_EQ = 6'd14,
    TK_NOT = 6'd15, TK_NE = 6'd16, TK_LT = 6'd17, TK_LE = 6'd18,
    TK_LSHIFT = 6'd19, TK_GT = 6'd20, TK_GE = 6'd21, TK_RSHIFT = 6'd22,
    TK_LPAREN = 6'd23, TK_RPAREN = 6'd24, TK_LBRACE = 6'd25, TK_RBRACE = 6'd26,
    TK_LBRACKET = 6'd27, TK_RBRACKET = 6'd28, TK_COLON = 6'd29, TK_DOT = 6'd30,
    TK_COMMA = 6'd31, TK_INT = 6'd32, TK_FLOAT = 6'd33, TK_IDENT = 6'd34,
    TK_KEYWORD = 6'd35, TK_STRING = 6'd36, TK_EOF = 6'd37;

  typedef struct packed {
    logic [1:0]  rk;
    logic [5:0]  tk;
    logic [3:0]  kw;
    logic [16:0] st;
    logic [16:0] en;
    logic [7:0]  pay;
    logic [2:0]  err;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  localparam logic [3:0] KW_LEN [14] = '{4'd3, 4'd5, 4'd3, 4'd2, 4'd5, 4'd6, 4'd2,
                                          4'd4, 4'd5, 4'd3, 4'd8, 4'd5, 4'd6, 4'd7};

  function automatic logic [7:0] kw_char(int k, logic [3:0] idx);
    logic [63:0] s;
    int l;
    case (k)
      0:  s = "var";
      1:  s = "const";
      2:  s = "ref";
      3:  s = "fn";
      4:  s = "class";
      5:  s = "struct";
      6:  s = "if";
      7:  s = "else";
      8:  s = "while";
      9:  s = "for";
      10: s = "continue";
      11: s = "break";
      12: s = "return";
      default: s = "include";
    endcase
    l = int'(KW_LEN[k]);
    if (int'(idx) >= l) return 8'd0;
    return s[(l - 1 - int'(idx)) * 8 +: 8];
  endfunction

  function automatic logic [13:0] kw_filter(logic [13:0] m, logic [3:0] len,
                                            logic [7:0] c);
    logic [13:0] r;
    r = m;
    for (int k = 0; k < 14; k++) begin
      if (m[k] && (len >= KW_LEN[k] || kw_char(k, len) != c)) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_decode(logic [7:0] a, logic [7:0] b);
    logic [4:0] da;
    logic [4:0] db;
    da = hex_val(a);
    db = hex_val(b);
    if (da[4]) return db[4] ? {da[3:0], db[3:0]} : {4'd0, da[3:0]};
    if (a == 8'h20 || a == 8'h09 || a == 8'h0a || a == 8'h0b || a == 8'h0c ||
        a == 8'h0d || a == "+")
      return db[4] ? {4'd0, db[3:0]} : 8'd0;
    if (a == "-") return db[4] ? 8'(8'd0 - {4'd0, db[3:0]}) : 8'd0;
    return 8'd0;
  endfunction

  function automatic rec_t mk_tok(logic [5:0] tk, logic [3:0] kw,
                                  logic [16:0] s, logic [16:0] e);
    rec_t r;
    r = '0;
    r.rk = REC_TOKEN;
    r.tk = tk;
    r.kw = kw;
    r.st = s;
    r.en = e;
    return r;
  endfunction

  function automatic rec_t mk_err(logic [2:0] code, logic [16:0] s, logic [16:0] e);
    rec_t r;
    r = '0;
    r.rk  = REC_ERROR;
    r.err = code;
    r.st  = s;
    r.en  = e;
    return r;
  endfunction

  function automatic rec_t mk_byte(logic [7:0] v);
    rec_t r;
    r = '0;
    r.rk  = REC_BYTE;
    r.pay = v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/source_lexer.sv =====
// ----------------------------------------------------------------------------
// source_lexer
// Byte-stream lexer producing token, string-byte and error records.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while s_tready is high. The lexer state
// machine classifies each byte in the cycle it is accepted and pushes zero,
// one or two records into a four-entry queue; the output side drains one
// record per cycle while m_tready is high. A record is registered into the
// queue when its byte is accepted and is shown once it reaches the head.
// Bytes that yield two records (an operator or number ended by punctuation,
// for instance) draw the queue down faster than it empties; s_tready drops
// while fewer than two entries are free, so such bytes can stall the input.
`default_nettype none

module source_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // source_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // token_kind[5:0], keyword_index[9:6], start_index[26:10], end_index[43:27],
  // payload_byte[51:44], error_code[54:52], zero[55]
  output logic [55:0]      m_tdata,
  output logic [1:0]       m_tuser,   // record_kind
  output logic             m_tlast    // last_of_run
);
  import slx_pkg::*;

  push_t push;
  rec_t  head;
  logic  room;
  logic  take;

  assign s_tready = room;
  assign take     = s_tvalid && room;

  slx_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .c    (s_tdata),
    .push (push)
  );

  slx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (m_tvalid),
    .head       (head),
    .pop        (m_tready)
  );

  assign m_tdata = {1'b0, head.err, head.pay, head.en, head.st, head.kw, head.tk};
  assign m_tuser = head.rk;
  assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== sv/slx_front.sv =====
// ----------------------------------------------------------------------------
// slx_front
// Lexer state machine: classifies each source byte, pushes 0..2 records.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    c,
  output slx_pkg::push_t     push
);
  import slx_pkg::*;

  localparam logic [3:0] M_IDLE = 4'd0, M_OP = 4'd1, M_LINE = 4'd2, M_BLOCK = 4'd3,
    M_BSTAR = 4'd4, M_NUMBER = 4'd5, M_IDENT = 4'd6, M_STRING = 4'd7, M_ESC = 4'd8,
    M_HEX1 = 4'd9, M_HEX2 = 4'd10, M_DEAD = 4'd11;

  logic [3:0]  mode, mode_next;
  logic [7:0]  pend, pend_next;
  logic [16:0] pos, pos_next;
  logic [16:0] ts, ts_next;
  logic [1:0]  dots, dots_next;
  logic [13:0] kmask, kmask_next;
  logic [3:0]  ilen, ilen_next;
  logic        qsingle, qsingle_next;
  logic [7:0]  hex1, hex1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pend <= '0; pos <= '0; ts <= '0; dots <= '0;
      kmask <= '1; ilen <= '0; qsingle <= 1'b0; hex1 <= '0;
    end else if (take) begin
      mode <= mode_next; pend <= pend_next; pos <= pos_next; ts <= ts_next;
      dots <= dots_next; kmask <= kmask_next; ilen <= ilen_next;
      qsingle <= qsingle_next; hex1 <= hex1_next;
    end
  end

  always_comb begin
    rec_t ra, rb;
    logic va, vb, redo, erred;
    logic [5:0] d;
    logic dv;
    logic [5:0] tk;
    logic [3:0] kw;
    logic [7:0] v;
    logic vv;
    ra = '0; rb = '0; va = 1'b0; vb = 1'b0; redo = 1'b0; erred = 1'b0;
    d = '0; dv = 1'b0; tk = TK_IDENT; kw = '0; v = '0; vv = 1'b0;
    mode_next = mode; pend_next = pend; pos_next = pos; ts_next = ts;
    dots_next = dots; kmask_next = kmask; ilen_next = ilen;
    qsingle_next = qsingle; hex1_next = hex1;
    push = '0;

    if (mode == M_DEAD) begin
      if (c == 8'd0) begin
        mode_next = M_IDLE;
        pos_next = '0;
      end
    end else if (c != 8'd0 && pos >= MAX_SOURCE) begin
      ra = mk_err(ERR_LONG, pos, pos + 17'd1);
      va = 1'b1;
      mode_next = M_DEAD;
    end else begin
      unique case (mode)
        M_OP: begin
          if (pend == "/" && c == "/") mode_next = M_LINE;
          else if (pend == "/" && c == "*") mode_next = M_BLOCK;
          else begin
            priority case (pend)
              "+": begin dv = c == "="; d = TK_ADDASSIGN; end
              "-": begin
                dv = c == "=" || c == ">";
                d = (c == "=") ? TK_SUBASSIGN : TK_ARROW;
              end
              "*": begin dv = c == "="; d = TK_MULASSIGN; end
              "/": begin dv = c == "="; d = TK_DIVASSIGN; end
              "&": begin dv = c == "&"; d = TK_AND; end
              "|": begin dv = c == "|"; d = TK_OR; end
              "=": begin dv = c == "="; d = TK_EQ; end
              "!": begin dv = c == "="; d = TK_NE; end
              "<": begin
                dv = c == "=" || c == "<";
                d = (c == "=") ? TK_LE : TK_LSHIFT;
              end
              default: begin
                dv = c == "=" || c == ">";
                d = (c == "=") ? TK_GE : TK_RSHIFT;
              end
            endcase
            mode_next = M_IDLE;
            va = 1'b1;
            if (dv) ra = mk_tok(d, 4'd0, ts, ts + 17'd2);
            else begin
              priority case (pend)
                "+": tk = TK_ADD;
                "-": tk = TK_SUB;
                "*": tk = TK_MUL;
                "/": tk = TK_DIV;
                "&": tk = TK_BAND;
                "|": tk = TK_BOR;
                "=": tk = TK_ASSIGN;
                "!": tk = TK_NOT;
                "<": tk = TK_LT;
                default: tk = TK_GT;
              endcase
              ra = mk_tok(tk, 4'd0, ts, ts + 17'd1);
              redo = 1'b1;
            end
          end
        end
        M_LINE: begin
          if (c == 8'h0a) mode_next = M_IDLE;
          else if (c == 8'd0) redo = 1'b1;
        end
        M_BLOCK, M_BSTAR: begin
          if (c == 8'd0) begin
            ra = mk_err(ERR_COMMENT, ts, ts + 17'd2); va = 1'b1; erred = 1'b1;
          end else if (mode == M_BSTAR && c == "/") mode_next = M_IDLE;
          else mode_next = (c == "*") ? M_BSTAR : M_BLOCK;
        end
        M_NUMBER: begin
          if (c >= "0" && c <= "9") begin
          end else if (c == ".") begin
            if (dots < 2'd2) dots_next = dots + 2'd1;
          end else if (dots >= 2'd2) begin
            ra = mk_err(ERR_NUMBER, ts, pos); va = 1'b1; erred = 1'b1;
          end else begin
            ra = mk_tok((dots == 2'd0) ? TK_INT : TK_FLOAT, 4'd0, ts, pos);
            va = 1'b1; redo = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter(c)) begin
            kmask_next = kw_filter(kmask, ilen, c);
            if (ilen < 4'd15) ilen_next = ilen + 4'd1;
          end else begin
            for (int k = 0; k < 14; k++) begin
              if (kmask[k] && KW_LEN[k] == ilen) begin
                tk = TK_KEYWORD; kw = 4'(k);
              end
            end
            ra = mk_tok(tk, kw, ts, pos); va = 1'b1; redo = 1'b1;
          end
        end
        M_STRING: begin
          if (c == 8'd0 || c == 8'h0a) begin
            ra = mk_err(ERR_STRING, ts, pos); va = 1'b1; erred = 1'b1;
          end else if (c == (qsingle ? 8'h27 : 8'h22)) begin
            ra = mk_tok(TK_STRING, 4'd0, ts, pos + 17'd1); va = 1'b1;
            mode_next = M_IDLE;
          end else if (c == 8'h5c) mode_next = M_ESC;
          else begin
            ra = mk_byte(c); va = 1'b1;
          end
        end
        M_ESC: begin
          vv = 1'b1;
          priority case (c)
            "a": v = 8'h07;
            "b": v = 8'h08;
            "f": v = 8'h0c;
            "n": v = 8'h0a;
            "r": v = 8'h0d;
            "t": v = 8'h09;
            "v": v = 8'h0b;
            8'h5c, 8'h27, 8'h22: v = c;
            "x": begin vv = 1'b0; mode_next = M_HEX1; end
            default: begin
              vv = 1'b0;
              ra = mk_err(ERR_ESCAPE, pos - 17'd1, pos); va = 1'b1; erred = 1'b1;
            end
          endcase
          if (vv) begin
            ra = mk_byte(v); va = 1'b1; mode_next = M_STRING;
          end
        end
        M_HEX1: begin
          if (c == 8'd0) begin
            ra = mk_err(ERR_HEX, pos - 17'd2, pos - 17'd1); va = 1'b1; erred = 1'b1;
          end else begin
            hex1_next = c; mode_next = M_HEX2;
          end
        end
        M_HEX2: begin
          if (c == 8'd0) begin
            ra = mk_err(ERR_HEX, pos - 17'd3, pos - 17'd2); va = 1'b1; erred = 1'b1;
          end else begin
            ra = mk_byte(hex_decode(hex1, c)); va = 1'b1; mode_next = M_STRING;
          end
        end
        default: redo = 1'b1;
      endcase

      if (redo) begin
        mode_next = M_IDLE;
        priority case (c)
          8'd0: begin rb = mk_tok(TK_EOF, 4'd0, pos - 17'd1, pos); vb = 1'b1; end
          8'h0a, 8'h20, 8'h09: begin end
          "+", "-", "*", "/", "&", "|", "=", "!", "<", ">": begin
            mode_next = M_OP; pend_next = c; ts_next = pos;
          end
          "(": begin rb = mk_tok(TK_LPAREN, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          ")": begin rb = mk_tok(TK_RPAREN, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          "{": begin rb = mk_tok(TK_LBRACE, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          "}": begin rb = mk_tok(TK_RBRACE, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          "[": begin rb = mk_tok(TK_LBRACKET, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          "]": begin rb = mk_tok(TK_RBRACKET, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          ":": begin rb = mk_tok(TK_COLON, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          ".": begin rb = mk_tok(TK_DOT, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          ",": begin rb = mk_tok(TK_COMMA, 4'd0, pos, pos + 17'd1); vb = 1'b1; end
          8'h22, 8'h27: begin
            mode_next = M_STRING; ts_next = pos; qsingle_next = (c == 8'h27);
          end
          default: begin
            if (c >= "0" && c <= "9") begin
              mode_next = M_NUMBER; ts_next = pos; dots_next = 2'd0;
            end else if (is_letter(c)) begin
              mode_next = M_IDENT; ts_next = pos; ilen_next = 4'd1;
              kmask_next = kw_filter('1, 4'd0, c);
            end else begin
              rb = mk_err(ERR_CHAR, pos, pos + 17'd1); vb = 1'b1; erred = 1'b1;
            end
          end
        endcase
      end

      if (c == 8'd0) begin
        pos_next = '0;
        mode_next = M_IDLE;
      end else begin
        pos_next = pos + 17'd1;
        if (erred) mode_next = M_DEAD;
      end
    end

    if (va && vb) begin
      push.n = 2'd2; push.r0 = ra; push.r1 = rb; push.r1.last = 1'b1;
    end else if (va) begin
      push.n = 2'd1; push.r0 = ra; push.r0.last = 1'b1;
    end else if (vb) begin
      push.n = 2'd1; push.r0 = rb; push.r0.last = 1'b1;
    end
    if (!take) push.n = 2'd0;
  end

endmodule

`default_nettype wire

// ===== sv/slx_queue.sv =====
// ----------------------------------------------------------------------------
// slx_queue
// Four-entry record queue: up to two writes, one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire slx_pkg::push_t push,
  output logic               room,
  output logic               head_valid,
  output slx_pkg::rec_t      head,
  input  wire logic          pop
);
  import slx_pkg::*;

  rec_t       mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       do_pop;

  assign do_pop     = pop && count != 3'd0;
  assign room       = count <= 3'd2;
  assign head_valid = count != 3'd0;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wptr] <= push.r0;
    if (push.n == 2'd2) mem[wptr + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      wptr  <= wptr + push.n;
      rptr  <= rptr + {1'b0, do_pop};
      count <= count + {1'b0, push.n} - {2'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== sv/slx_checker.sv =====
// ----------------------------------------------------------------------------
// slx_checker
// Port-level checks on the lexer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);
  import slx_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output record changed while stalled");

  a_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REC_BYTE |-> m_tdata[43:0] == 44'd0 && m_tdata[55:52] == 4'd0)
    else $error("string byte record carries token fields");

  a_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REC_ERROR |-> m_tdata[9:0] == 10'd0 && m_tlast)
    else $error("error record malformed or not last");

endmodule

bind source_lexer slx_checker u_slx_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
